/* design/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by every module of the block.
package rau_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
	localparam int RES_NUM_WIDTH = PROD_WIDTH + 1;
	localparam int SHIFT_WIDTH   = $clog2(PROD_WIDTH);

	typedef enum logic [1:0] {
		ACT_REDUCE = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_SUB    = 2'd2,
		ACT_NEGATE = 2'd3
	} action_t;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_ZERO_DEN = 1'b1;

	typedef struct packed {
		action_t                           action;
		logic signed [OPERAND_WIDTH-1:0]   num_a;
		logic signed [OPERAND_WIDTH-1:0]   den_a;
		logic signed [OPERAND_WIDTH-1:0]   num_b;
		logic signed [OPERAND_WIDTH-1:0]   den_b;
	} req_word_t;

	typedef struct packed {
		logic signed [RES_NUM_WIDTH-1:0]   res_num;
		logic signed [PROD_WIDTH-1:0]      res_den;
		logic                              status;
	} rsp_word_t;

	// Request to the shared add/subtract unit.
	typedef struct packed {
		logic [PROD_WIDTH-1:0] a;
		logic [PROD_WIDTH-1:0] b;
		logic                  sub;
	} alu_req_t;

	// Result of the shared unit; carry set on subtract means a >= b.
	typedef struct packed {
		logic [PROD_WIDTH-1:0] res;
		logic                  carry;
	} alu_rsp_t;

endpackage

/* design/rau_mul.sv */
// Registered unsigned magnitude multiplier, one product per cycle.
// Depends on rau_pkg.
module rau_mul (
	input  logic                               clk,
	input  logic [rau_pkg::OPERAND_WIDTH-1:0]  a,
	input  logic [rau_pkg::OPERAND_WIDTH-1:0]  b,
	output logic [rau_pkg::PROD_WIDTH-1:0]     p
);
	import rau_pkg::*;

	logic [PROD_WIDTH-1:0] prod;
	logic [PROD_WIDTH-1:0] p_q;

	assign prod = PROD_WIDTH'(a) * PROD_WIDTH'(b);

	always_ff @(posedge clk) begin
		p_q <= prod;
	end

	assign p = p_q;

endmodule

/* design/rau_alu.sv */
// Shared add/subtract and compare unit, used by combine, GCD and divide steps.
// Depends on rau_pkg.
module rau_alu (
	input  rau_pkg::alu_req_t  req,
	output rau_pkg::alu_rsp_t  rsp
);
	import rau_pkg::*;

	logic [PROD_WIDTH:0] sum;

	// Subtract as a + ~b + 1; carry out then flags a >= b.
	assign sum = {1'b0, req.a} + {1'b0, req.b ^ {PROD_WIDTH{req.sub}}}
		+ (PROD_WIDTH+1)'(req.sub);

	assign rsp.res   = sum[PROD_WIDTH-1:0];
	assign rsp.carry = sum[PROD_WIDTH];

endmodule

/* design/rational_arith_unit.sv */
// Top level of the rational arithmetic unit: sequencer, operand and result registers.
// Depends on rau_pkg, rau_mul and rau_alu.
//
// Usage: a request word carries an action (reduce A, A+B, A-B, negate A) and two
// signed fractions A = num_a/den_a and B = num_b/den_b. The response word holds the
// result reduced by the GCD of its magnitudes, each part keeping its computed sign,
// or status = zero-denominator with a 0/0 result.
// Both channels are valid/ready; a word moves on an edge where both are high.
// One request is worked on at a time: req_ready is high only while the sequencer
// waits for work. A request runs through these steps in order:
//   accept, two cross products and the denominator product on one shared multiplier,
//   combine, retried once with the operands swapped if it borrowed, zero checks,
//   stripping the t common factors of two (t < 2*OPERAND_WIDTH),
//   binary GCD steps on the shared add/subtract unit, the last one the exit,
//   restoring division of the numerator and then the denominator by the GCD,
//   and a load into the response register.
// Reduce and negate skip the products and the combine. The GCD loop and the two
// divisions all run on the one add/subtract unit; a zero numerator or denominator
// goes from the zero checks straight to the response register.
// Stall: the response register holds its word until rsp_ready; a finished result
// waits in the sequencer until that register is free, and the sequencer does not
// take a new request meanwhile.
// Reset clears the sequencer to idle and drops any pending response.
module rational_arith_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rau_pkg::req_word_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rau_pkg::rsp_word_t  rsp
);
	import rau_pkg::*;

	localparam logic [SHIFT_WIDTH-1:0] CNT_LAST = SHIFT_WIDTH'(PROD_WIDTH - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MULD,
		S_COMB,
		S_COMB2,
		S_CHECK,
		S_TWOS,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_DONE
	} state_t;

	function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] x);
		mag_of = x[OPERAND_WIDTH-1] ? (~x + 1'b1) : x;
	endfunction

	state_t                    state_q;
	action_t                   act_q;
	logic [OPERAND_WIDTH-1:0]  mna_q, mda_q, mnb_q, mdb_q;
	logic                      sna_q, sda_q, snb_q, sdb_q;
	logic [PROD_WIDTH-1:0]     m1_q, m2_q;
	logic                      s1_q, s2_q;
	logic [PROD_WIDTH-1:0]     mn_q, md_q;
	logic                      sn_q, sd_q;
	logic                      err_q;
	logic [PROD_WIDTH-1:0]     u_q, v_q, g_q;
	logic [SHIFT_WIDTH-1:0]    k_q;
	logic [PROD_WIDTH-1:0]     rem_q, quo_q;
	logic [SHIFT_WIDTH-1:0]    cnt_q;
	logic                      rsp_valid_q;
	rsp_word_t                 rsp_q;

	logic [OPERAND_WIDTH-1:0]  mul_a, mul_b;
	logic [PROD_WIDTH-1:0]     prod;
	alu_req_t                  alu_req;
	alu_rsp_t                  alu_rsp;
	logic [PROD_WIDTH-1:0]     rem_shift;
	logic [PROD_WIDTH-1:0]     quo_next;
	logic                      req_take;

	assign req_ready = (state_q == S_IDLE);
	assign req_take  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Pick multiplier operands for the product of the current step: a cross product or the denominator product.
	always_comb begin
		case (state_q)
			S_MUL1:  begin mul_a = mna_q; mul_b = mdb_q; end
			S_MUL2:  begin mul_a = mda_q; mul_b = mnb_q; end
			default: begin mul_a = mda_q; mul_b = mdb_q; end
		endcase
	end

	rau_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign rem_shift = {rem_q[PROD_WIDTH-2:0], quo_q[PROD_WIDTH-1]};

	// Route the shared unit to whichever step owns it this cycle.
	always_comb begin
		alu_req.a   = m1_q;
		alu_req.b   = m2_q;
		alu_req.sub = s1_q ^ s2_q;
		case (state_q)
			S_COMB2: begin
				alu_req.a   = m2_q;
				alu_req.b   = m1_q;
				alu_req.sub = 1'b1;
			end
			S_GCD: begin
				alu_req.a   = v_q;
				alu_req.b   = u_q;
				alu_req.sub = 1'b1;
			end
			S_DIVN, S_DIVD: begin
				alu_req.a   = rem_shift;
				alu_req.b   = g_q;
				alu_req.sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	rau_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign quo_next = {quo_q[PROD_WIDTH-2:0], alu_rsp.carry};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// Drop the word once taken; a finished result reloads it in S_DONE.
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						act_q <= req.action;
						sna_q <= req.num_a[OPERAND_WIDTH-1];
						sda_q <= req.den_a[OPERAND_WIDTH-1];
						snb_q <= req.num_b[OPERAND_WIDTH-1];
						sdb_q <= req.den_b[OPERAND_WIDTH-1];
						mna_q <= mag_of(req.num_a);
						mda_q <= mag_of(req.den_a);
						mnb_q <= mag_of(req.num_b);
						mdb_q <= mag_of(req.den_b);
						// Reduce and negate take A as it stands, negate with the numerator sign flipped.
						mn_q  <= PROD_WIDTH'(mag_of(req.num_a));
						md_q  <= PROD_WIDTH'(mag_of(req.den_a));
						sn_q  <= req.num_a[OPERAND_WIDTH-1] ^ (req.action == ACT_NEGATE);
						sd_q  <= req.den_a[OPERAND_WIDTH-1];
						err_q <= 1'b0;
						if (req.action == ACT_ADD || req.action == ACT_SUB) begin
							state_q <= S_MUL1;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					m1_q    <= prod;
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					m2_q    <= prod;
					state_q <= S_MULD;
				end
				S_MULD: begin
					md_q    <= prod;
					sd_q    <= sda_q ^ sdb_q;
					s1_q    <= sna_q ^ sdb_q;
					s2_q    <= sda_q ^ snb_q ^ (act_q == ACT_SUB);
					state_q <= S_COMB;
				end
				S_COMB: begin
					// Same signs add; otherwise subtract, retry swapped if it borrowed.
					if (!(s1_q ^ s2_q) || alu_rsp.carry) begin
						mn_q    <= alu_rsp.res;
						sn_q    <= s1_q;
						state_q <= S_CHECK;
					end else begin
						state_q <= S_COMB2;
					end
				end
				S_COMB2: begin
					mn_q    <= alu_rsp.res;
					sn_q    <= s2_q;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (md_q == '0) begin
						err_q   <= 1'b1;
						mn_q    <= '0;
						state_q <= S_DONE;
					end else if (mn_q == '0) begin
						// gcd(0, d) is d: result is 0 over a unit denominator.
						sn_q    <= 1'b0;
						md_q    <= PROD_WIDTH'(1);
						state_q <= S_DONE;
					end else begin
						u_q     <= mn_q;
						v_q     <= md_q;
						k_q     <= '0;
						state_q <= S_TWOS;
					end
				end
				S_TWOS: begin
					if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (v_q == '0) begin
						g_q     <= u_q << k_q;
						rem_q   <= '0;
						quo_q   <= mn_q;
						cnt_q   <= '0;
						state_q <= S_DIVN;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (alu_rsp.carry) begin
						v_q <= alu_rsp.res;
					end else begin
						// Keep u the smaller one.
						u_q <= v_q;
						v_q <= u_q;
					end
				end
				S_DIVN: begin
					if (cnt_q == CNT_LAST) begin
						mn_q    <= quo_next;
						rem_q   <= '0;
						quo_q   <= md_q;
						cnt_q   <= '0;
						state_q <= S_DIVD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						rem_q <= alu_rsp.carry ? alu_rsp.res : rem_shift;
						quo_q <= quo_next;
					end
				end
				S_DIVD: begin
					cnt_q <= cnt_q + 1'b1;
					rem_q <= alu_rsp.carry ? alu_rsp.res : rem_shift;
					quo_q <= quo_next;
					if (cnt_q == CNT_LAST) begin
						md_q    <= quo_next;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold the result until the response register is free.
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.res_num <= sn_q ? -{1'b0, mn_q} : {1'b0, mn_q};
						rsp_q.res_den <= err_q ? '0 : (sd_q ? -md_q : md_q);
						rsp_q.status  <= err_q ? STATUS_ZERO_DEN : STATUS_OK;
						rsp_valid_q   <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
